/* sv/pc_pkg.sv */
// ----------------------------------------------------------------------------
// pc_pkg
// Shared widths and the accumulated-series record for the correlation block.
// ----------------------------------------------------------------------------
package pc_pkg;

    localparam int MAX_PAIRS   = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int IN_W        = 24;
    localparam int COUNT_W     = 13;
    localparam int SUM_W       = 36;
    localparam int SQ_W        = 60;
    localparam int OP_W        = 72;    // multiplier operand
    localparam int PROD_W      = 144;   // multiplier product
    localparam int FRAC_BITS   = 60;    // Q1.30 squared
    localparam int DIV_W       = 202;   // Sxy^2 << 60 fits here
    localparam int QUO_W       = 61;    // r^2 in Q1.60
    localparam int QCNT_W      = 7;
    localparam int ROOT_W      = 62;
    localparam int COEF_W      = 32;
    localparam int QDEPTH      = 2;

    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        logic signed [SUM_W-1:0]   sum_x;
        logic signed [SUM_W-1:0]   sum_y;
        logic [SQ_W-1:0]           sum_xx;
        logic [SQ_W-1:0]           sum_yy;
        logic signed [SQ_W-1:0]    sum_xy;
        logic                      overflow;
    } series_t;

endpackage

/* sv/pc_front.sv */
// ----------------------------------------------------------------------------
// pc_front
// Takes one sample pair per cycle while the queue is not full and keeps the
// running sums; on the last pair it hands the finished series to the queue and clears.
// ----------------------------------------------------------------------------
module pc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pc_pkg::IN_W-1:0]       x_sample,
    input  logic [pc_pkg::IN_W-1:0]       y_sample,
    input  logic                          last_pair,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic                          queue_full,
    output logic                          push,
    output pc_pkg::series_t               push_data
);

    logic [pc_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic signed [pc_pkg::SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [pc_pkg::SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic [pc_pkg::SQ_W-1:0]          sum_xx_reg, sum_xx_next;
    logic [pc_pkg::SQ_W-1:0]          sum_yy_reg, sum_yy_next;
    logic signed [pc_pkg::SQ_W-1:0]   sum_xy_reg, sum_xy_next;
    logic                             ovf_reg, ovf_next;

    logic signed [pc_pkg::IN_W-1:0]   x_s;
    logic signed [pc_pkg::IN_W-1:0]   y_s;
    logic signed [2*pc_pkg::IN_W-1:0] xx;
    logic signed [2*pc_pkg::IN_W-1:0] yy;
    logic signed [2*pc_pkg::IN_W-1:0] xy;
    logic                             accept;
    logic                             at_max;

    assign x_s = pc_pkg::IN_W'(signed'(x_sample[pc_pkg::SAMPLE_BITS-1:0]));
    assign y_s = pc_pkg::IN_W'(signed'(y_sample[pc_pkg::SAMPLE_BITS-1:0]));
    assign xx  = x_s * x_s;
    assign yy  = y_s * y_s;
    assign xy  = x_s * y_s;

    assign sample_stall = queue_full;
    assign accept       = sample_valid && !queue_full;
    assign at_max       = (count_reg == pc_pkg::COUNT_W'(pc_pkg::MAX_PAIRS));

    always_comb
    begin
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xx_next = sum_xx_reg;
        sum_yy_next = sum_yy_reg;
        sum_xy_next = sum_xy_reg;
        ovf_next    = ovf_reg;
        if (at_max)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            count_next  = count_reg + pc_pkg::COUNT_W'(1);
            sum_x_next  = sum_x_reg + pc_pkg::SUM_W'(x_s);
            sum_y_next  = sum_y_reg + pc_pkg::SUM_W'(y_s);
            sum_xx_next = sum_xx_reg + pc_pkg::SQ_W'($unsigned(xx));
            sum_yy_next = sum_yy_reg + pc_pkg::SQ_W'($unsigned(yy));
            sum_xy_next = sum_xy_reg + pc_pkg::SQ_W'(xy);
        end
    end

    assign push             = accept && last_pair;
    assign push_data.count    = count_next;
    assign push_data.sum_x    = sum_x_next;
    assign push_data.sum_y    = sum_y_next;
    assign push_data.sum_xx   = sum_xx_next;
    assign push_data.sum_yy   = sum_yy_next;
    assign push_data.sum_xy   = sum_xy_next;
    assign push_data.overflow = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last_pair)
            begin
                count_reg  <= '0;
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_xx_reg <= '0;
                sum_yy_reg <= '0;
                sum_xy_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                sum_x_reg  <= sum_x_next;
                sum_y_reg  <= sum_y_next;
                sum_xx_reg <= sum_xx_next;
                sum_yy_reg <= sum_yy_next;
                sum_xy_reg <= sum_xy_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule

/* sv/pc_queue.sv */
// ----------------------------------------------------------------------------
// pc_queue
// Two-entry queue of finished series between accumulator and solver.
// ----------------------------------------------------------------------------
module pc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pc_pkg::series_t push_data,
    output logic            full,
    input  logic            pop,
    output pc_pkg::series_t pop_data,
    output logic            empty
);

    pc_pkg::series_t mem_reg [pc_pkg::QDEPTH];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;

    assign full     = (cnt_reg == 2'(pc_pkg::QDEPTH));
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(pc_pkg::QDEPTH)) else $error("queue count out of range");

endmodule

/* sv/pc_back.sv */
// ----------------------------------------------------------------------------
// pc_back
// Solver: forms Sxx, Syy, Sxy and their products on a shift-add multiplier,
// divides Sxy^2 * 2^60 by Sxx*Syy, then takes the integer square root.
// ----------------------------------------------------------------------------
module pc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              queue_empty,
    output logic                              pop,
    input  pc_pkg::series_t                   pop_data,
    output logic signed [pc_pkg::COEF_W-1:0]  coefficient,
    output logic                              zero_spread,
    output logic                              too_long,
    output logic [pc_pkg::COUNT_W-1:0]        pair_count,
    output logic                              result_valid,
    input  logic                              result_stall
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int OP_W   = pc_pkg::OP_W;
    localparam int PROD_W = pc_pkg::PROD_W;
    localparam int DIV_W  = pc_pkg::DIV_W;
    localparam int ROOT_W = pc_pkg::ROOT_W;
    localparam int QUO_W  = pc_pkg::QUO_W;
    localparam int SUM_W  = pc_pkg::SUM_W;
    localparam int SQ_W   = pc_pkg::SQ_W;

    logic [2:0]                  state_reg;
    logic [2:0]                  step_reg;
    pc_pkg::series_t             ent_reg;
    logic [PROD_W-1:0]           mul_a_reg;
    logic [OP_W-1:0]             mul_b_reg;
    logic [PROD_W-1:0]           mul_p_reg;
    logic signed [OP_W:0]        tmp_reg;
    logic [OP_W-1:0]             sxx_reg;
    logic [OP_W-1:0]             syy_reg;
    logic signed [OP_W:0]        sxy_reg;
    logic [PROD_W-1:0]           den_reg;
    logic [DIV_W-1:0]            rem_reg;
    logic [DIV_W-1:0]            dvs_reg;
    logic [QUO_W-1:0]            quo_reg;
    logic [pc_pkg::QCNT_W-1:0]   cnt_reg;
    logic [ROOT_W-1:0]           num_reg;
    logic [ROOT_W-1:0]           res_reg;
    logic [ROOT_W-1:0]           bit_reg;
    logic [pc_pkg::COEF_W-1:0]   coef_reg;
    logic                        flat_reg;

    logic                        out_valid_reg;
    logic [pc_pkg::COEF_W-1:0]   out_coef_reg;
    logic                        out_flat_reg;
    logic                        out_long_reg;
    logic [pc_pkg::COUNT_W-1:0]  out_count_reg;

    logic [SUM_W-1:0]            sx_mag;
    logic [SUM_W-1:0]            sy_mag;
    logic [SQ_W-1:0]             sxy_in_mag;
    logic [OP_W-1:0]             sxy_mag;
    logic [OP_W-1:0]             op_a;
    logic [OP_W-1:0]             op_b;
    logic signed [OP_W:0]        p_pos;
    logic signed [OP_W:0]        p_neg;
    logic signed [OP_W:0]        diff;
    logic                        ge;
    logic [ROOT_W-1:0]           root_try;
    logic                        root_fit;
    logic [ROOT_W-1:0]           res_next;
    logic [30:0]                 q_mag;
    logic                        out_free;

    assign sx_mag     = ent_reg.sum_x[SUM_W-1] ? (~ent_reg.sum_x + SUM_W'(1)) : ent_reg.sum_x;
    assign sy_mag     = ent_reg.sum_y[SUM_W-1] ? (~ent_reg.sum_y + SUM_W'(1)) : ent_reg.sum_y;
    assign sxy_in_mag = ent_reg.sum_xy[SQ_W-1] ? (~ent_reg.sum_xy + SQ_W'(1)) : ent_reg.sum_xy;
    assign sxy_mag    = sxy_reg[OP_W] ? OP_W'(-sxy_reg) : OP_W'(sxy_reg);

    always_comb
    begin
        case (step_reg)
            3'd0:    begin op_a = OP_W'(ent_reg.count); op_b = OP_W'(ent_reg.sum_xx); end
            3'd1:    begin op_a = OP_W'(sx_mag);        op_b = OP_W'(sx_mag);         end
            3'd2:    begin op_a = OP_W'(ent_reg.count); op_b = OP_W'(ent_reg.sum_yy); end
            3'd3:    begin op_a = OP_W'(sy_mag);        op_b = OP_W'(sy_mag);         end
            3'd4:    begin op_a = OP_W'(ent_reg.count); op_b = OP_W'(sxy_in_mag);     end
            3'd5:    begin op_a = OP_W'(sx_mag);        op_b = OP_W'(sy_mag);         end
            3'd6:    begin op_a = sxx_reg;              op_b = syy_reg;               end
            default: begin op_a = sxy_mag;              op_b = sxy_mag;               end
        endcase
    end

    assign p_pos    = $signed({1'b0, mul_p_reg[OP_W-1:0]});
    assign p_neg    = -p_pos;
    assign diff     = tmp_reg - p_pos;
    assign ge       = (rem_reg >= dvs_reg);
    assign root_try = res_reg + bit_reg;
    assign root_fit = (num_reg >= root_try);
    assign res_next = root_fit ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    assign q_mag    = res_next[30:0];
    assign out_free = !out_valid_reg || !result_stall;
    assign pop      = (state_reg == ST_IDLE) && !queue_empty;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ent_reg  <= pop_data;
                coef_reg <= '0;
                flat_reg <= 1'b0;
            end
            ST_LOAD:
            begin
                mul_a_reg <= PROD_W'(op_a);
                mul_b_reg <= op_b;
                mul_p_reg <= '0;
            end
            ST_MUL:
            begin
                if (mul_b_reg == '0)
                begin
                    case (step_reg)
                        3'd0, 3'd2: tmp_reg <= p_pos;
                        3'd1:       sxx_reg <= diff[OP_W-1:0];
                        3'd3:
                        begin
                            syy_reg <= diff[OP_W-1:0];
                            if (sxx_reg == '0 || diff[OP_W-1:0] == '0)
                            begin
                                flat_reg <= 1'b1;
                            end
                        end
                        3'd4: tmp_reg <= ent_reg.sum_xy[SQ_W-1] ? p_neg : p_pos;
                        3'd5:
                        begin
                            sxy_reg <= (ent_reg.sum_x[SUM_W-1] ^ ent_reg.sum_y[SUM_W-1])
                                       ? (tmp_reg + p_pos) : (tmp_reg - p_pos);
                        end
                        3'd6: den_reg <= mul_p_reg;
                        default:
                        begin
                            rem_reg <= DIV_W'(mul_p_reg) << pc_pkg::FRAC_BITS;
                            dvs_reg <= DIV_W'(den_reg) << pc_pkg::FRAC_BITS;
                            quo_reg <= '0;
                            cnt_reg <= pc_pkg::QCNT_W'(QUO_W);
                        end
                    endcase
                end
                else
                begin
                    if (mul_b_reg[0])
                    begin
                        mul_p_reg <= mul_p_reg + mul_a_reg;
                    end
                    mul_a_reg <= mul_a_reg << 1;
                    mul_b_reg <= mul_b_reg >> 1;
                end
            end
            ST_DIV:
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg <= dvs_reg >> 1;
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                cnt_reg <= cnt_reg - pc_pkg::QCNT_W'(1);
                num_reg <= ROOT_W'({quo_reg[QUO_W-2:0], ge});
                res_reg <= '0;
                bit_reg <= ROOT_W'(1) << (QUO_W - 1);
            end
            ST_SQRT:
            begin
                if (root_fit)
                begin
                    num_reg <= num_reg - root_try;
                end
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                coef_reg <= sxy_reg[OP_W] ? -pc_pkg::COEF_W'(q_mag)
                                          : pc_pkg::COEF_W'(q_mag);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= 3'd0;
                    if (!queue_empty)
                    begin
                        state_reg <= pop_data.overflow ? ST_FIN : ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (mul_b_reg == '0)
                    begin
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd3 &&
                            (sxx_reg == '0 || diff[OP_W-1:0] == '0))
                        begin
                            state_reg <= ST_FIN;
                        end
                        else if (step_reg == 3'd7)
                        begin
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == pc_pkg::QCNT_W'(1))
                    begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (bit_reg == ROOT_W'(1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FIN && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            out_coef_reg  <= coef_reg;
            out_flat_reg  <= flat_reg;
            out_long_reg  <= ent_reg.overflow;
            out_count_reg <= ent_reg.count;
        end
    end

    assign result_valid = out_valid_reg;
    assign coefficient  = out_coef_reg;
    assign zero_spread  = out_flat_reg;
    assign too_long     = out_long_reg;
    assign pair_count   = out_count_reg;

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (zero_spread || too_long) |-> coefficient == '0)
        else $error("flagged result with nonzero coefficient");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(zero_spread && too_long))
        else $error("both flags set");
    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (coefficient <= 32'sd1073741824 &&
                          coefficient >= -32'sd1073741824))
        else $error("coefficient out of range");
    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQRT |-> bit_reg != '0)
        else $error("root step without bit");

endmodule

/* sv/pearson_correlation.sv */
// ----------------------------------------------------------------------------
// pearson_correlation
// Pearson correlation of a paired sample stream, Q1.30 result per series.
// ----------------------------------------------------------------------------
// The accumulator takes one pair per cycle with no gaps inside a series. On
// the last pair the sums go to a two-entry queue and a serial solver produces
// the result: eight shift-add products of up to 72 bits, a 61-step restoring
// divide and a 31-step square root. The accumulator keeps taking pairs while
// the solver works and stalls only while both queue entries wait for the
// solver. A flat or overlong series skips the divide and root.
module pearson_correlation (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pc_pkg::IN_W-1:0]           x_sample,
    input  logic [pc_pkg::IN_W-1:0]           y_sample,
    input  logic                              last_pair,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    output logic signed [pc_pkg::COEF_W-1:0]  coefficient,
    output logic                              zero_spread,
    output logic                              too_long,
    output logic [pc_pkg::COUNT_W-1:0]        pair_count,
    output logic                              result_valid,
    input  logic                              result_stall
);

    logic            push;
    logic            full;
    logic            pop;
    logic            empty;
    pc_pkg::series_t push_data;
    pc_pkg::series_t pop_data;

    pc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .last_pair    (last_pair),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .queue_full   (full),
        .push         (push),
        .push_data    (push_data)
    );

    pc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    pc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (empty),
        .pop          (pop),
        .pop_data     (pop_data),
        .coefficient  (coefficient),
        .zero_spread  (zero_spread),
        .too_long     (too_long),
        .pair_count   (pair_count),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

/* tb/tb_pearson_correlation.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pearson_correlation
// Streams paired sample series into the correlation block under random
// sender gaps and receiver stalls, predicts each series result with exact
// wide arithmetic and checks every result field in order.
// ----------------------------------------------------------------------------
module tb_pearson_correlation;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 1000;

    typedef struct {
        logic signed [pc_pkg::COEF_W-1:0] coef;
        logic                             flat;
        logic                             over;
        logic [pc_pkg::COUNT_W-1:0]       count;
    } corr_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic [pc_pkg::IN_W-1:0]          x_sample;
    logic [pc_pkg::IN_W-1:0]          y_sample;
    logic                             last_pair;
    logic                             sample_valid;
    logic                             sample_stall;
    logic signed [pc_pkg::COEF_W-1:0] coefficient;
    logic                             zero_spread;
    logic                             too_long;
    logic [pc_pkg::COUNT_W-1:0]       pair_count;
    logic                             result_valid;
    logic                             result_stall;

    pearson_correlation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .last_pair    (last_pair),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .coefficient  (coefficient),
        .zero_spread  (zero_spread),
        .too_long     (too_long),
        .pair_count   (pair_count),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // series accumulators of the predictor
    int unsigned       acc_n;
    logic signed [63:0] acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    logic              acc_over;

    corr_result_t pending_results[$];
    int  gap_pct;
    int  stall_pct;
    int  failures;
    int  cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    function automatic corr_result_t correlate();
        corr_result_t       r;
        logic signed [255:0] n, sxx, syy, sxy;
        logic [255:0]        mag, den, num, c;
        logic [31:0]         q;
        r.count = acc_n[pc_pkg::COUNT_W-1:0];
        r.over  = acc_over;
        r.flat  = 1'b0;
        r.coef  = '0;
        if (!acc_over)
        begin
            n   = acc_n;
            sxx = n * 256'(acc_xx) - 256'(acc_x) * 256'(acc_x);
            syy = n * 256'(acc_yy) - 256'(acc_y) * 256'(acc_y);
            sxy = n * 256'(acc_xy) - 256'(acc_x) * 256'(acc_y);
            if (sxx == 0 || syy == 0)
                r.flat = 1'b1;
            else
            begin
                mag = (sxy < 0) ? -sxy : sxy;
                den = sxx * syy;
                num = (mag * mag) << 60;
                q = '0;
                for (int b = 30; b >= 0; b--)
                begin
                    c = q | (32'd1 << b);
                    if (c * c * den <= num)
                        q = c[31:0];
                end
                r.coef = (sxy < 0) ? -q : q;
            end
        end
        return r;
    endfunction

    task automatic accumulate(input logic [pc_pkg::IN_W-1:0] xv,
                              input logic [pc_pkg::IN_W-1:0] yv,
                              input logic lst);
        logic signed [63:0] xs, ys;
        xs = 64'(signed'(xv));
        ys = 64'(signed'(yv));
        if (acc_n >= pc_pkg::MAX_PAIRS)
            acc_over = 1'b1;
        else
        begin
            acc_n++;
            acc_x  += xs;
            acc_y  += ys;
            acc_xx += xs * xs;
            acc_yy += ys * ys;
            acc_xy += xs * ys;
        end
        if (lst)
        begin
            pending_results.insert(pending_results.size(), correlate());
            acc_n = 0; acc_x = 0; acc_y = 0;
            acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_over = 1'b0;
        end
    endtask

    task automatic send_pair(input logic [pc_pkg::IN_W-1:0] xv,
                             input logic [pc_pkg::IN_W-1:0] yv,
                             input logic lst);
        logic ok;
        if ($urandom_range(99) < gap_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge clk);
        end
        sample_valid <= 1'b1;
        x_sample     <= xv;
        y_sample     <= yv;
        last_pair    <= lst;
        do
        begin
            @(negedge clk);
            ok = !sample_stall;
            @(posedge clk);
        end while (!ok);
        accumulate(xv, yv, lst);
    endtask

    // result check: sample mid-cycle, count the item at the following edge
    logic                             rx_take;
    logic signed [pc_pkg::COEF_W-1:0] rx_coef;
    logic                             rx_flat, rx_over;
    logic [pc_pkg::COUNT_W-1:0]       rx_count;

    always @(negedge clk)
    begin
        rx_take  = rst_n && result_valid && !result_stall;
        rx_coef  = coefficient;
        rx_flat  = zero_spread;
        rx_over  = too_long;
        rx_count = pair_count;
    end

    always @(posedge clk)
    begin
        corr_result_t e;
        if (rx_take)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result coefficient %0d", rx_coef);
                failures++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (rx_coef !== e.coef)
                begin
                    $error("coefficient expected %0d actual %0d", e.coef, rx_coef);
                    failures++;
                end
                if (rx_flat !== e.flat)
                begin
                    $error("zero_spread expected %0b actual %0b", e.flat, rx_flat);
                    failures++;
                end
                if (rx_over !== e.over)
                begin
                    $error("too_long expected %0b actual %0b", e.over, rx_over);
                    failures++;
                end
                if (rx_count !== e.count)
                begin
                    $error("pair_count expected %0d actual %0d", e.count, rx_count);
                    failures++;
                end
            end
        end
    end

    function automatic logic [pc_pkg::IN_W-1:0] rand_sample(input int span);
        case (span)
            0:       return pc_pkg::IN_W'($urandom);
            1:       return pc_pkg::IN_W'($urandom_range(16) - 8);
            default: return $urandom_range(1) ? {1'b0, {(pc_pkg::IN_W-1){1'b1}}}
                                              : {1'b1, {(pc_pkg::IN_W-1){1'b0}}};
        endcase
    endfunction

    task automatic test_directed();
        logic [pc_pkg::IN_W-1:0] maxv, minv;
        maxv = {1'b0, {(pc_pkg::IN_W-1){1'b1}}};
        minv = {1'b1, {(pc_pkg::IN_W-1){1'b0}}};
        // single pair: flat
        send_pair(maxv, minv, 1'b1);
        // constant x: flat
        send_pair(pc_pkg::IN_W'(5), pc_pkg::IN_W'(1), 1'b0);
        send_pair(pc_pkg::IN_W'(5), pc_pkg::IN_W'(-3), 1'b1);
        // full-scale perfect correlation and strong anticorrelation
        send_pair(maxv, maxv, 1'b0);
        send_pair(minv, minv, 1'b1);
        send_pair(maxv, minv, 1'b0);
        send_pair(minv, maxv, 1'b0);
        send_pair('0, '0, 1'b1);
        // partial correlation
        send_pair(pc_pkg::IN_W'(1), pc_pkg::IN_W'(3), 1'b0);
        send_pair(pc_pkg::IN_W'(2), pc_pkg::IN_W'(-1), 1'b0);
        send_pair(pc_pkg::IN_W'(-7), pc_pkg::IN_W'(4), 1'b0);
        send_pair('1, pc_pkg::IN_W'(-2), 1'b1);
    endtask

    task automatic test_length_limit();
        // one pair past the maximum length
        for (int i = 0; i < pc_pkg::MAX_PAIRS + 1; i++)
            send_pair(rand_sample(i % 3), rand_sample((i + 1) % 3),
                      i == pc_pkg::MAX_PAIRS);
    endtask

    task automatic test_random(input int items);
        int sent, len, span;
        sent = 0;
        while (sent < items)
        begin
            len  = ($urandom_range(19) == 0) ? $urandom_range(300, 1)
                                             : $urandom_range(20, 1);
            span = $urandom_range(2);
            for (int i = 0; i < len; i++)
            begin
                send_pair(rand_sample(span), $urandom_range(3) == 0 ? rand_sample(0)
                          : rand_sample(span), i == len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        x_sample     = '0;
        y_sample     = '0;
        last_pair    = 1'b0;
        result_stall = 1'b0;
        gap_pct      = 10;
        stall_pct    = 80;
        failures     = 0;
        cycles       = 0;
        acc_n = 0; acc_x = 0; acc_y = 0;
        acc_xx = 0; acc_yy = 0; acc_xy = 0; acc_over = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300);
        gap_pct   = 80;
        stall_pct = 10;
        test_random(300);
        gap_pct   = 0;
        stall_pct = 0;
        test_length_limit();
        test_random(300);

        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
